[rtl/bse_pkg.sv]
package bse_pkg;

  localparam int TABLE_POINTS = 11;
  localparam int IDX_W = $clog2(TABLE_POINTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_POINTS - 1);

  localparam int MV_W = 15;
  localparam int LEVEL_W = 14;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 14'd10000;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN = 14'd0;
  localparam logic [LEVEL_W-1:0] SLEW_RESET = 14'd100;

  // one table segment spans ten percent, in hundredths
  localparam int SPAN_PC = 1000;
  localparam int DIV_W = 10;
  localparam int Q_W = 10;
  localparam int NUM_W = 20;
  localparam int CNT_W = $clog2(Q_W);

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHEMISTRY = 1'd0,
    REG_SLEW_LIMIT = 1'd1
  } cfg_reg_t;

  localparam logic [MV_W-1:0] LEAD_MV [TABLE_POINTS] = '{
    15'd12700, 15'd12580, 15'd12460, 15'd12360, 15'd12280, 15'd12200,
    15'd12060, 15'd11900, 15'd11750, 15'd11580, 15'd11400
  };
  localparam logic [MV_W-1:0] LFP_MV [TABLE_POINTS] = '{
    15'd13400, 15'd13300, 15'd13250, 15'd13220, 15'd13200, 15'd13180,
    15'd13150, 15'd13100, 15'd13000, 15'd12900, 15'd12000
  };
  localparam logic [LEVEL_W-1:0] LEVELS [TABLE_POINTS] = '{
    14'd10000, 14'd9000, 14'd8000, 14'd7000, 14'd6000, 14'd5000,
    14'd4000, 14'd3000, 14'd2000, 14'd1000, 14'd0
  };

  typedef struct packed {
    logic [MV_W-1:0] battery_mv;
    logic            battery_ok;
    logic [MV_W-1:0] panel_mv;
    logic            panel_ok;
  } sample_t;

  typedef struct packed {
    logic               soc_valid;
    logic [LEVEL_W-1:0] soc_level;
    logic               is_charging;
  } report_t;

  typedef struct packed {
    logic load;
    logic clear_est;
    logic set_charge;
    logic want_top;
    logic want_bot;
    logic idx_init;
    logic idx_inc;
    logic div_init;
    logic div_step;
    logic want_interp;
    logic update_est;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic bat_ok;
    logic charging;
    logic above_top;
    logic below_bot;
    logic seg_hit;
    logic at_last;
    logic div_last;
  } status_t;

  function automatic logic [MV_W-1:0] table_mv(input logic chem,
                                               input logic [IDX_W-1:0] idx);
    logic [MV_W-1:0] v;
    v = '0;
    if (idx <= LAST_IDX) begin
      v = chem ? LFP_MV[idx] : LEAD_MV[idx];
    end
    return v;
  endfunction

  function automatic logic [LEVEL_W-1:0] table_level(input logic [IDX_W-1:0] idx);
    logic [LEVEL_W-1:0] v;
    v = '0;
    if (idx <= LAST_IDX) begin
      v = LEVELS[idx];
    end
    return v;
  endfunction

endpackage

[rtl/bse_datapath.sv]
module bse_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  bse_pkg::sample_t                sample,
  input  logic                            cfg_we,
  input  logic [bse_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bse_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  bse_pkg::cmd_t                   cmd,
  output bse_pkg::status_t                status,
  output bse_pkg::report_t                report
);
  import bse_pkg::*;

  logic [MV_W-1:0]    bat_mv;
  logic               bat_ok;
  logic [MV_W-1:0]    pan_mv;
  logic               pan_ok;
  logic               chem;
  logic [LEVEL_W-1:0] slew;
  logic               have_est;
  logic [LEVEL_W-1:0] est;
  logic               charge;
  logic [LEVEL_W-1:0] want;
  logic [IDX_W-1:0]   idx;
  logic [NUM_W-1:0]   rem;
  logic [NUM_W-1:0]   dsh;
  logic [Q_W-1:0]     quot;
  logic [CNT_W-1:0]   div_cnt;
  report_t            report_q;

  logic [MV_W-1:0]    mv_cur;
  logic [MV_W-1:0]    mv_prev;
  logic [MV_W-1:0]    diff_mv;
  logic [MV_W-1:0]    span_mv;
  logic [NUM_W-1:0]   numerator;
  logic [LEVEL_W:0]   est_up;
  logic [LEVEL_W:0]   want_up;
  logic [LEVEL_W-1:0] est_next;

  assign mv_cur = table_mv(chem, idx);
  assign mv_prev = table_mv(chem, idx - 1'b1);
  assign diff_mv = bat_mv - mv_cur;
  assign span_mv = mv_prev - mv_cur;
  assign numerator = NUM_W'(diff_mv[DIV_W-1:0]) * NUM_W'(SPAN_PC);

  assign status.bat_ok = bat_ok;
  assign status.charging = pan_ok && (pan_mv > bat_mv);
  assign status.above_top = bat_mv >= table_mv(chem, '0);
  assign status.below_bot = bat_mv <= table_mv(chem, LAST_IDX);
  assign status.seg_hit = bat_mv >= mv_cur;
  assign status.at_last = idx == LAST_IDX;
  assign status.div_last = div_cnt == CNT_W'(Q_W - 1);

  assign est_up = {1'b0, est} + {1'b0, slew};
  assign want_up = {1'b0, want} + {1'b0, slew};

  always_comb begin
    if (!have_est) begin
      est_next = want;
    end else if ({1'b0, want} > est_up) begin
      est_next = est_up[LEVEL_W-1:0];
    end else if (want_up < {1'b0, est}) begin
      est_next = est - slew;
    end else begin
      est_next = want;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chem <= 1'b0;
      slew <= SLEW_RESET;
      have_est <= 1'b0;
      est <= '0;
      charge <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_CHEMISTRY:  chem <= cfg_data[0];
          REG_SLEW_LIMIT: slew <= cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clear_est) begin
        have_est <= 1'b0;
        est <= '0;
      end
      if (cmd.set_charge) begin
        charge <= status.charging;
      end
      if (cmd.update_est) begin
        have_est <= 1'b1;
        est <= est_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bat_mv <= sample.battery_mv;
      bat_ok <= sample.battery_ok;
      pan_mv <= sample.panel_mv;
      pan_ok <= sample.panel_ok;
    end
    if (cmd.want_top) begin
      want <= LEVEL_MAX;
    end else if (cmd.want_bot) begin
      want <= LEVEL_MIN;
    end else if (cmd.want_interp) begin
      want <= table_level(idx) + LEVEL_W'(quot);
    end
    if (cmd.idx_init) begin
      idx <= IDX_W'(1);
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
    if (cmd.div_init) begin
      rem <= numerator;
      dsh <= NUM_W'(span_mv[DIV_W-1:0]) << (Q_W - 1);
      quot <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quot <= {quot[Q_W-2:0], 1'b1};
      end else begin
        quot <= {quot[Q_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.out_load) begin
      report_q.soc_valid <= have_est;
      report_q.soc_level <= have_est ? est : '0;
      report_q.is_charging <= charge;
    end
  end

  assign report = report_q;

`ifndef ASSERT_OFF
  a_est_range: assert property (@(posedge clk) disable iff (rst)
    have_est |-> est <= LEVEL_MAX)
    else $error("estimate out of range");
  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    cmd.want_interp |-> quot < Q_W'(SPAN_PC))
    else $error("interpolation step exceeds segment");
  a_want_range: assert property (@(posedge clk) disable iff (rst)
    cmd.update_est |-> want <= LEVEL_MAX)
    else $error("target level out of range");
`endif

endmodule

[rtl/bse_controller.sv]
module bse_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  output logic               report_valid,
  input  logic               report_ready,
  input  bse_pkg::status_t   status,
  output bse_pkg::cmd_t      cmd
);
  import bse_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_DIVIDE,
    S_WANT,
    S_SLEW,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign sample_ready = state == S_IDLE;
  assign out_free = !report_valid || report_ready;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!status.bat_ok) begin
          cmd.clear_est = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.set_charge = 1'b1;
          if (status.charging) begin
            state_next = S_DONE;
          end else if (status.above_top) begin
            cmd.want_top = 1'b1;
            state_next = S_SLEW;
          end else if (status.below_bot) begin
            cmd.want_bot = 1'b1;
            state_next = S_SLEW;
          end else begin
            cmd.idx_init = 1'b1;
            state_next = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (status.seg_hit) begin
          cmd.div_init = 1'b1;
          state_next = S_DIVIDE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_WANT;
        end
      end
      S_WANT: begin
        cmd.want_interp = 1'b1;
        state_next = S_SLEW;
      end
      S_SLEW: begin
        cmd.update_est = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      report_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        report_valid <= 1'b1;
      end else if (report_ready) begin
        report_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("item accepted while busy");
  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> !status.at_last || status.seg_hit)
    else $error("segment search ran past table end");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !report_valid || report_ready)
    else $error("result overwritten before taken");
`endif

endmodule

[rtl/battery_soc_estimator_unit.sv]
// Battery state-of-charge estimator. Each item on the sample channel is one
// periodic reading; it yields exactly one item on the report channel. An
// item may have to wait for the report register to free up. A battery
// reading that is invalid or a charging decision passes through idle,
// check and done, and a voltage beyond either end of the table through
// idle, check, slew and done. A voltage inside the table walks the table
// one entry per cycle to find its segment, then runs a shift-subtract
// divider for the interpolation. One item is in work at a time; a finished
// report waits in its own register so the next sample can be taken before
// it is read. Chemistry and slew limit are written through
// cfg_we/cfg_index/cfg_data and should only change while the block is idle.
module battery_soc_estimator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  bse_pkg::sample_t                sample,
  output logic                            report_valid,
  input  logic                            report_ready,
  output bse_pkg::report_t                report,
  input  logic                            cfg_we,
  input  logic [bse_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bse_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bse_pkg::*;

  cmd_t    cmd;
  status_t status;

  bse_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .status       (status),
    .cmd          (cmd)
  );

  bse_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .report    (report)
  );

endmodule

[verif/bse_checker.sv]
`timescale 1ns / 1ps

module bse_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  input  logic                           sample_ready,
  input  bse_pkg::sample_t               sample,
  input  logic                           report_valid,
  input  logic                           report_ready,
  input  bse_pkg::report_t               report,
  input  logic                           cfg_we,
  input  logic [bse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bse_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending
);
  import bse_pkg::*;

  localparam int PRINT_MAX = 50;

  // shadow copy of the block's registers and state
  logic               chem;
  logic [LEVEL_W-1:0] slew;
  logic               have_est;
  logic [LEVEL_W-1:0] est;
  logic               chg;

  report_t want_reports[$];
  report_t head;
  int      err_count = 0;
  int      rpt_count = 0;

  function automatic int knee_mv(input logic lfp, input int i);
    int v;
    case (i)
      0: v = lfp ? 13400 : 12700;
      1: v = lfp ? 13300 : 12580;
      2: v = lfp ? 13250 : 12460;
      3: v = lfp ? 13220 : 12360;
      4: v = lfp ? 13200 : 12280;
      5: v = lfp ? 13180 : 12200;
      6: v = lfp ? 13150 : 12060;
      7: v = lfp ? 13100 : 11900;
      8: v = lfp ? 13000 : 11750;
      9: v = lfp ? 12900 : 11580;
      default: v = lfp ? 12000 : 11400;
    endcase
    return v;
  endfunction

  // target level in hundredths of a percent, clamped and interpolated
  function automatic int target_level(input int mv, input logic lfp);
    int hi;
    int lo;
    if (mv >= knee_mv(lfp, 0)) return 10000;
    if (mv <= knee_mv(lfp, 10)) return 0;
    for (int i = 1; i < 11; i++) begin
      hi = knee_mv(lfp, i - 1);
      lo = knee_mv(lfp, i);
      if (mv >= lo) begin
        return (10 - i) * 1000 + ((mv - lo) * 1000) / (hi - lo);
      end
    end
    return 0;
  endfunction

  function automatic report_t predict_report(input sample_t s);
    report_t r;
    int      want;
    int      cur;
    int      lim;
    if (!s.battery_ok) begin
      have_est = 1'b0;
      est = '0;
    end else begin
      chg = s.panel_ok && (s.panel_mv > s.battery_mv);
      if (!chg) begin
        want = target_level(int'(s.battery_mv), chem);
        if (!have_est) begin
          est = want[LEVEL_W-1:0];
          have_est = 1'b1;
        end else begin
          cur = int'(est);
          lim = int'(slew);
          if (want > cur + lim) begin
            cur = cur + lim;
          end else if (want < cur - lim) begin
            cur = cur - lim;
          end else begin
            cur = want;
          end
          est = cur[LEVEL_W-1:0];
        end
      end
    end
    r.soc_valid = have_est;
    r.soc_level = have_est ? est : '0;
    r.is_charging = chg;
    return r;
  endfunction

  task automatic flag_error(input string field, input int got, input int want_v);
    if (err_count < PRINT_MAX) begin
      $display("ERROR item %0d %s: got %0d, want %0d", rpt_count, field, got, want_v);
    end
    err_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      chem = 1'b0;
      slew = 14'd100;
      have_est = 1'b0;
      est = '0;
      chg = 1'b0;
      want_reports.delete();
    end else begin
      if (report_valid && report_ready) begin
        if (want_reports.size() == 0) begin
          flag_error("unexpected item", 0, 0);
        end else begin
          head = want_reports.pop_front();
          if (report.soc_valid != head.soc_valid) begin
            flag_error("soc_valid", int'(report.soc_valid), int'(head.soc_valid));
          end
          if (report.soc_level != head.soc_level) begin
            flag_error("soc_level", int'(report.soc_level), int'(head.soc_level));
          end
          if (report.is_charging != head.is_charging) begin
            flag_error("is_charging", int'(report.is_charging), int'(head.is_charging));
          end
        end
        rpt_count++;
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_CHEMISTRY: begin
            chem = cfg_data[0];
          end
          REG_SLEW_LIMIT: begin
            slew = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (sample_valid && sample_ready) begin
        want_reports.insert(want_reports.size(), predict_report(sample));
      end
    end
    errors <= err_count;
    pending <= want_reports.size();
  end

endmodule

[verif/tb_battery_soc_estimator_unit.sv]
`timescale 1ns / 1ps

module tb_battery_soc_estimator_unit;
  import bse_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 204;
  localparam int HOLD_AT = 500;
  localparam int HOLD_CYCLES = 300;

  logic                  clk;
  logic                  rst;
  logic                  sample_valid;
  logic                  sample_ready;
  sample_t               sample;
  logic                  report_valid;
  logic                  report_ready;
  report_t               report;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int  errors;
  int  pending;
  int  stall_cnt = 0;
  int  rcv_count = 0;
  logic cur_lfp;

  battery_soc_estimator_unit dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample),
    .report_valid(report_valid),
    .report_ready(report_ready),
    .report(report),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  bse_checker chk (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample),
    .report_valid(report_valid),
    .report_ready(report_ready),
    .report(report),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic sample_t mk(input int bmv, input bit bok, input int pmv, input bit pok);
    sample_t s;
    s.battery_mv = bmv[MV_W-1:0];
    s.battery_ok = bok;
    s.panel_mv = pmv[MV_W-1:0];
    s.panel_ok = pok;
    return s;
  endfunction

  function automatic sample_t random_sample(input logic lfp);
    int r;
    int b;
    int p;
    int k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, TABLE_POINTS - 1);
    if (r < 70) begin
      b = lfp ? $urandom_range(11900, 13500) : $urandom_range(11300, 12800);
    end else if (r < 82) begin
      b = lfp ? int'(LFP_MV[k]) : int'(LEAD_MV[k]);
    end else if (r < 94) begin
      b = $urandom_range(0, 20000);
    end else begin
      b = $urandom_range(0, 32767);
    end
    if ($urandom_range(0, 1) == 1) begin
      p = b + int'($urandom_range(0, 400)) - 200;
    end else begin
      p = $urandom_range(0, 32767);
    end
    if (p < 0) p = 0;
    if (p > 32767) p = 32767;
    return mk(b, $urandom_range(0, 9) != 0, p, $urandom_range(0, 1) == 1);
  endfunction

  task automatic push_sample(input sample_t s);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic apply_settings(input logic lfp, input logic [CFG_DATA_W-1:0] slew);
    logic [CFG_DATA_W-1:0] chem_word;
    chem_word = CFG_DATA_W'($urandom_range(0, 16383));
    chem_word[0] = lfp;
    cfg_we <= 1'b1;
    cfg_index <= REG_CHEMISTRY;
    cfg_data <= chem_word;
    @(posedge clk);
    cfg_index <= REG_SLEW_LIMIT;
    cfg_data <= slew;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_lfp = lfp;
  endtask

  // receiver with random gaps and one long hold-off
  initial begin
    int gap;
    report_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 7) == 0) begin
        gap = 0;
      end
      if (rcv_count == HOLD_AT) begin
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        report_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      report_ready <= 1'b1;
      @(posedge clk);
      while (!report_valid) @(posedge clk);
      rcv_count++;
    end
  end

  always @(posedge clk) begin
    if ((sample_valid && sample_ready) || (report_valid && report_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic                  lfp;
    logic [CFG_DATA_W-1:0] slew;
    rst <= 1'b1;
    sample_valid <= 1'b0;
    sample <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    cur_lfp = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // charging with no estimate, adoption, clamps, freeze, invalid battery
    push_sample(mk(12000, 1, 13000, 1));
    push_sample(mk(12000, 1, 12000, 1));
    push_sample(mk(13000, 1, 32767, 0));
    push_sample(mk(12700, 1, 0, 1));
    push_sample(mk(11400, 1, 0, 0));
    push_sample(mk(11000, 1, 11001, 1));
    push_sample(mk(0, 1, 0, 0));
    push_sample(mk(32767, 1, 0, 1));
    push_sample(mk(32767, 0, 32767, 1));
    push_sample(mk(0, 0, 0, 0));
    push_sample(mk(11000, 1, 0, 0));
    for (int i = 1; i < TABLE_POINTS - 1; i++) begin
      push_sample(mk(int'(LEAD_MV[i]), 1, 0, 0));
    end
    push_sample(mk(15'h5555, 1, 15'h2aaa, 1));
    push_sample(mk(15'h2aaa, 1, 15'h5555, 1));

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin lfp = 1'b1; slew = 14'd0; end
        1: begin lfp = 1'b0; slew = 14'd16383; end
        2: begin lfp = 1'b1; slew = 14'd10000; end
        3: begin lfp = 1'b0; slew = 14'd1; end
        4: begin lfp = 1'b1; slew = 14'd100; end
        default: begin
          lfp = 1'($urandom_range(0, 1));
          slew = ($urandom_range(0, 1) == 1) ? CFG_DATA_W'($urandom_range(0, 16383))
                                             : CFG_DATA_W'($urandom_range(0, 500));
        end
      endcase
      apply_settings(lfp, slew);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        push_sample(random_sample(cur_lfp));
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/bse_pkg.sv
rtl/bse_datapath.sv
rtl/bse_controller.sv
rtl/battery_soc_estimator_unit.sv
verif/bse_checker.sv
verif/tb_battery_soc_estimator_unit.sv
